>>> rtl/cdad_pkg.sv
// Shared types, constants and the month-length function of the date adder.
package cdad_pkg;

  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned YearMin       = 1;
  localparam int unsigned YearMax       = 9999;

  // Lengths of January through December in a common year.
  localparam logic [4:0] MonthDays [MonthsPerYear] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_DATE   = 2'd1,
    ST_YEAR_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    B_IDLE,
    B_STEP
  } back_state_e;

  typedef struct packed {
    logic        [4:0]  start_day;
    logic        [3:0]  start_month;
    logic        [13:0] start_year;
    logic signed [15:0] delta_days;
  } in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [1:0]  status;
  } out_t;

  // One classified item waiting for the stepper.
  typedef struct packed {
    logic               bad;
    logic signed [16:0] day;
    logic        [3:0]  month;
    logic signed [14:0] year;
  } job_t;

  // Month length; February gains a day when the year is divisible by four.
  function automatic logic [4:0] days_in_month(logic [3:0] month, logic leap);
    logic [4:0] len;
    if (month < 4'd1 || month > 4'(MonthsPerYear)) begin
      len = 5'd31;
    end else begin
      len = MonthDays[month - 4'd1];
      if (month == 4'd2 && leap) begin
        len = len + 5'd1;
      end
    end
    return len;
  endfunction

endpackage

>>> rtl/cdad_front.sv
// Front end: checks the starting date and forms the initial day sum.
module cdad_front
  import cdad_pkg::*;
(
  input  in_t  req_i,
  output job_t job_o
);

  logic [4:0] start_len;
  logic       month_ok;
  logic       year_ok;
  logic       day_ok;

  assign start_len = days_in_month(req_i.start_month, req_i.start_year[1:0] == 2'd0);
  assign month_ok  = req_i.start_month >= 4'd1 && req_i.start_month <= 4'(MonthsPerYear);
  assign year_ok   = req_i.start_year >= 14'(YearMin) && req_i.start_year <= 14'(YearMax);
  assign day_ok    = req_i.start_day >= 5'd1 && req_i.start_day <= start_len;

  assign job_o.bad   = !(month_ok && year_ok && day_ok);
  assign job_o.day   = {req_i.delta_days[15], req_i.delta_days} + {12'd0, req_i.start_day};
  assign job_o.month = req_i.start_month;
  assign job_o.year  = {1'b0, req_i.start_year};

endmodule

>>> rtl/cdad_fifo.sv
// Small queue of classified items between the front end and the stepper.
module cdad_fifo
  import cdad_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/cdad_back.sv
// Back end: walks the date one month per cycle and registers the result.
module cdad_back
  import cdad_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic done_o,
  output out_t res_o
);

  back_state_e        state_q, state_d;
  logic signed [16:0] day_q, day_d;
  logic        [3:0]  month_q, month_d;
  logic signed [14:0] year_q, year_d;
  logic               done_q;
  out_t               res_q, res_d;
  logic               emit;

  logic        [4:0]  cur_len;
  logic        [4:0]  prev_len;
  logic        [3:0]  prev_month;
  logic signed [14:0] prev_year;
  logic               go_fwd;
  logic               go_back;
  logic               year_ok;

  assign cur_len    = days_in_month(month_q, year_q[1:0] == 2'd0);
  assign prev_month = (month_q == 4'd1) ? 4'(MonthsPerYear) : month_q - 4'd1;
  assign prev_year  = (month_q == 4'd1) ? year_q - 15'sd1 : year_q;
  assign prev_len   = days_in_month(prev_month, prev_year[1:0] == 2'd0);
  assign go_fwd     = day_q > $signed({12'd0, cur_len});
  assign go_back    = day_q < 17'sd1;
  assign year_ok    = year_q >= 15'sd1 && year_q <= $signed(15'(YearMax));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i && !job_i.bad) begin
          state_d = B_STEP;
        end
      end
      B_STEP: begin
        if (!go_fwd && !go_back) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath and result formation.
  always_comb begin
    pop_o   = 1'b0;
    emit    = 1'b0;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    res_d   = res_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          day_d   = job_i.day;
          month_d = job_i.month;
          year_d  = job_i.year;
          if (job_i.bad) begin
            emit  = 1'b1;
            res_d = '{result_day: '0, result_month: '0, result_year: '0,
                      status: ST_BAD_DATE};
          end
        end
      end
      B_STEP: begin
        priority if (go_fwd) begin
          day_d = day_q - {12'd0, cur_len};
          if (month_q == 4'(MonthsPerYear)) begin
            month_d = 4'd1;
            year_d  = year_q + 15'sd1;
          end else begin
            month_d = month_q + 4'd1;
          end
        end else if (go_back) begin
          // Move into the previous month first, then add its length.
          month_d = prev_month;
          year_d  = prev_year;
          day_d   = day_q + {12'd0, prev_len};
        end else begin
          emit = 1'b1;
          if (year_ok) begin
            res_d = '{result_day: day_q[4:0], result_month: month_q,
                      result_year: year_q[13:0], status: ST_OK};
          end else begin
            res_d = '{result_day: '0, result_month: '0, result_year: '0,
                      status: ST_YEAR_RANGE};
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/calendar_date_add_days.sv
// Top level of the date adder: front end, item queue and month stepper.
//
// Usage: present a date and a signed day offset on req_i and raise start.
// The item is transferred at a rising edge where start is high and busy is
// low; busy is high only while the item queue is full. Each item yields one
// result on res_o, shown for exactly one cycle while done_o is high. The
// receiver cannot stall, so results must be captured in that cycle.
// An invalid start date is flagged by the front end; its error result is
// registered once the stepper pops it from the queue. A valid one is
// popped, then walked across each month boundary it crosses (up to about
// 1080 for an offset of 32767 days) before its result is registered; any
// item may also wait in the queue first. The stepper advances one month
// per cycle and works on one item at a time; an invalid item skips stepping.
// Reset (rst_ni low) empties the queue and returns the stepper to idle;
// no item in flight survives it.
module calendar_date_add_days_core
  import cdad_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  req_i,
  output logic busy,
  output logic done_o,
  output out_t res_o
);

  job_t front_job;
  job_t queue_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic push;

  assign busy = q_full;
  assign push = start && !q_full;

  cdad_front u_front (
    .req_i (req_i),
    .job_o (front_job)
  );

  cdad_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .pop_i   (q_pop),
    .data_o  (queue_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cdad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (queue_job),
    .pop_o   (q_pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

`ifndef NO_ASSERTIONS
  // A transferred item must be visible in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_empty)
    else $error("transferred item missing from queue");

  // Error results carry an all-zero date.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |->
      (res_o.result_day == '0 && res_o.result_month == '0 && res_o.result_year == '0))
    else $error("error result with nonzero date");

  // The stepper never pops from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
